[hdl/tlc_pkg.sv]
// Shared types and constants for the two-level cache tag lookup.
// No dependencies; imported by tlc_level and the top level.
package tlc_pkg;

  localparam int ADDR_W = 32;
  localparam int TAG_W  = 32;
  // One way entry in a set row: {valid, tag}
  localparam int ENT_W  = TAG_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_L1_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L1_INDEX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_L1_WAYS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_L2_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_L2_INDEX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_L2_WAYS   = 3'd5;

  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_RHIT  = 3'd1;
  localparam logic [2:0] ST_RMISS = 3'd2;
  localparam logic [2:0] ST_WHIT  = 3'd3;
  localparam logic [2:0] ST_WMISS = 3'd4;

  typedef struct packed {
    logic cap;     // capture compare results from the read row
    logic commit;  // a fill is written back this cycle
  } lvl_ctl_t;

endpackage

[hdl/tlc_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
module tlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/tlc_level.sv]
// One cache level: address split, way compare, fill way choice, round-robin pointer.
// Depends on tlc_pkg; the set row comes from a tlc_ram owned by the top level.
module tlc_level import tlc_pkg::*; #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8,
  parameter int CFG_W    = 4,
  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  localparam int ROW_W  = MAX_WAYS * ENT_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [3:0]        cfg_off,
  input  logic [3:0]        cfg_idx,
  input  logic [CFG_W-1:0]  cfg_ways,
  input  logic [ADDR_W-1:0] address,
  input  logic [ROW_W-1:0]  rdata,
  input  lvl_ctl_t          ctl,
  output logic [SET_W-1:0]  set_idx,
  output logic              hit,
  output logic [ROW_W-1:0]  wdata
);

  localparam int MIB   = $clog2(MAX_SETS + 1) - 1;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WC_W  = $clog2(MAX_WAYS + 1);

  logic [WC_W-1:0]   ways_eff;
  logic [3:0]        ib;
  logic [4:0]        tag_sh;
  logic [ADDR_W-1:0] shifted;
  logic [TAG_W-1:0]  tag;
  logic              hit_c;
  logic              any_inv;
  logic [WAY_W-1:0]  first_inv;
  logic [WAY_W-1:0]  victim_c;

  logic              hit_q;
  logic              use_ptr;
  logic [WAY_W-1:0]  victim;
  logic [ROW_W-1:0]  row;
  logic [WAY_W-1:0]  ptr;

  always_comb begin
    if (cfg_ways == '0) begin
      ways_eff = WC_W'(1);
    end else if (int'(cfg_ways) > MAX_WAYS) begin
      ways_eff = WC_W'(MAX_WAYS);
    end else begin
      ways_eff = WC_W'(cfg_ways);
    end
    ib = (int'(cfg_idx) > MIB) ? 4'(MIB) : cfg_idx;
  end

  assign tag_sh  = {1'b0, cfg_off} + {1'b0, ib};
  assign shifted = address >> cfg_off;
  assign set_idx = shifted[SET_W-1:0] & ~({SET_W{1'b1}} << ib);
  assign tag     = address >> tag_sh;

  always_comb begin
    hit_c     = 1'b0;
    any_inv   = 1'b0;
    first_inv = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < int'(ways_eff)) begin
        if (rdata[w*ENT_W + TAG_W] && rdata[w*ENT_W +: TAG_W] == tag) begin
          hit_c = 1'b1;
        end
        if (!rdata[w*ENT_W + TAG_W]) begin
          any_inv   = 1'b1;
          first_inv = WAY_W'(w);
        end
      end
    end
    if (any_inv) begin
      victim_c = first_inv;
    end else if (int'(ptr) < int'(ways_eff)) begin
      victim_c = ptr;
    end else begin
      victim_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      hit_q   <= hit_c;
      use_ptr <= !any_inv;
      victim  <= victim_c;
      row     <= rdata;
    end
  end

  // advance the shared pointer only when no invalid way was free
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (ctl.commit && use_ptr) begin
      if (int'(victim) + 1 >= int'(ways_eff)) begin
        ptr <= '0;
      end else begin
        ptr <= victim + WAY_W'(1);
      end
    end
  end

  always_comb begin
    wdata = row;
    wdata[victim*ENT_W +: ENT_W] = {1'b1, tag};
  end

  assign hit = hit_q;

endmodule

[hdl/two_level_cache_tag_lookup.sv]
// Two-level (L1/L2) set-associative cache tag lookup with round-robin fill.
// Depends on tlc_pkg, tlc_level and tlc_ram.
// Each accepted word passes through these steps: accept and read both set rows,
// compare, write back any fill, then hand the status to the output register
// (waiting while the output is held). After reset the block sweeps the
// max(L1_MAX_SETS, L2_MAX_SETS) set addresses, clearing the valid bits of both
// tag memories, before it accepts a word; configuration writes are taken at any time.
module two_level_cache_tag_lookup import tlc_pkg::*; #(
  parameter int L1_MAX_SETS = 256,
  parameter int L1_MAX_WAYS = 8,
  parameter int L2_MAX_SETS = 1024,
  parameter int L2_MAX_WAYS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // [31:0] address
  input  logic                  s_tuser,   // [0] cmd (0 read, 1 write)
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [2:0] L1 outcome, [5:3] L2 outcome
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int L1_SET_W = (L1_MAX_SETS > 1) ? $clog2(L1_MAX_SETS) : 1;
  localparam int L2_SET_W = (L2_MAX_SETS > 1) ? $clog2(L2_MAX_SETS) : 1;
  localparam int L1_ROW_W = L1_MAX_WAYS * ENT_W;
  localparam int L2_ROW_W = L2_MAX_WAYS * ENT_W;
  localparam int CLR_N    = (L1_MAX_SETS > L2_MAX_SETS) ? L1_MAX_SETS : L2_MAX_SETS;
  localparam int CNT_W    = $clog2(CLR_N + 1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_ACT  = 3'd3;
  localparam logic [2:0] S_SEND = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] clr_cnt;
  logic [31:0]      addr;
  logic             cmd;
  logic [2:0]       res1;
  logic [2:0]       res2;
  logic             send_go;

  logic [3:0] l1_offset_bits, l1_index_bits, l1_ways;
  logic [3:0] l2_offset_bits, l2_index_bits;
  logic [4:0] l2_ways;

  logic [31:0]         look_addr;
  logic [L1_SET_W-1:0] l1_set;
  logic [L2_SET_W-1:0] l2_set;
  logic [L1_ROW_W-1:0] l1_rdata, l1_fill, l1_wd;
  logic [L2_ROW_W-1:0] l2_rdata, l2_fill, l2_wd;
  logic [L1_SET_W-1:0] l1_wa;
  logic [L2_SET_W-1:0] l2_wa;
  logic                l1_hit, l2_hit;
  logic                l1_we, l2_we;
  logic                l1_fill_en, l2_fill_en;
  lvl_ctl_t            l1_ctl, l2_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_offset_bits <= 4'd6;
      l1_index_bits  <= 4'd6;
      l1_ways        <= 4'd4;
      l2_offset_bits <= 4'd6;
      l2_index_bits  <= 4'd8;
      l2_ways        <= 5'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_L1_OFFSET: l1_offset_bits <= cfg_data[3:0];
        REG_L1_INDEX:  l1_index_bits  <= cfg_data[3:0];
        REG_L1_WAYS:   l1_ways        <= cfg_data[3:0];
        REG_L2_OFFSET: l2_offset_bits <= cfg_data[3:0];
        REG_L2_INDEX:  l2_index_bits  <= cfg_data[3:0];
        REG_L2_WAYS:   l2_ways        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready  = (state == S_IDLE);
  assign look_addr = (state == S_IDLE) ? s_tdata : addr;

  assign l1_fill_en = (state == S_ACT) && !cmd && !l1_hit;
  assign l2_fill_en = l1_fill_en && !l2_hit;
  assign l1_ctl = '{cap: state == S_LOOK, commit: l1_fill_en};
  assign l2_ctl = '{cap: state == S_LOOK, commit: l2_fill_en};

  tlc_level #(.MAX_SETS(L1_MAX_SETS), .MAX_WAYS(L1_MAX_WAYS), .CFG_W(4)) u_l1 (
    .clk, .rst,
    .cfg_off(l1_offset_bits), .cfg_idx(l1_index_bits), .cfg_ways(l1_ways),
    .address(look_addr), .rdata(l1_rdata), .ctl(l1_ctl),
    .set_idx(l1_set), .hit(l1_hit), .wdata(l1_fill)
  );

  tlc_level #(.MAX_SETS(L2_MAX_SETS), .MAX_WAYS(L2_MAX_WAYS), .CFG_W(5)) u_l2 (
    .clk, .rst,
    .cfg_off(l2_offset_bits), .cfg_idx(l2_index_bits), .cfg_ways(l2_ways),
    .address(look_addr), .rdata(l2_rdata), .ctl(l2_ctl),
    .set_idx(l2_set), .hit(l2_hit), .wdata(l2_fill)
  );

  // clearing sweep writes all-invalid rows
  assign l1_we = (state == S_CLR) ? (int'(clr_cnt) < L1_MAX_SETS) : l1_fill_en;
  assign l2_we = (state == S_CLR) ? (int'(clr_cnt) < L2_MAX_SETS) : l2_fill_en;
  assign l1_wa = (state == S_CLR) ? clr_cnt[L1_SET_W-1:0] : l1_set;
  assign l2_wa = (state == S_CLR) ? clr_cnt[L2_SET_W-1:0] : l2_set;
  assign l1_wd = (state == S_CLR) ? '0 : l1_fill;
  assign l2_wd = (state == S_CLR) ? '0 : l2_fill;

  tlc_ram #(.WIDTH(L1_ROW_W), .DEPTH(L1_MAX_SETS)) u_l1_ram (
    .clk, .we(l1_we), .waddr(l1_wa), .wdata(l1_wd), .raddr(l1_set), .rdata(l1_rdata)
  );

  tlc_ram #(.WIDTH(L2_ROW_W), .DEPTH(L2_MAX_SETS)) u_l2_ram (
    .clk, .we(l2_we), .waddr(l2_wa), .wdata(l2_wd), .raddr(l2_set), .rdata(l2_rdata)
  );

  // hand over the status once the output register is free
  assign send_go = (state == S_SEND) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (send_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + CNT_W'(1);
          if (int'(clr_cnt) == CLR_N - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: state <= S_ACT;
        S_ACT:  state <= S_SEND;
        S_SEND: begin
          if (send_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      addr <= s_tdata;
      cmd  <= s_tuser;
    end
    if (state == S_ACT) begin
      if (l1_hit) begin
        res1 <= cmd ? ST_WHIT : ST_RHIT;
        res2 <= ST_NONE;
      end else if (cmd) begin
        res1 <= ST_WMISS;
        res2 <= l2_hit ? ST_WHIT : ST_WMISS;
      end else begin
        res1 <= ST_RMISS;
        res2 <= l2_hit ? ST_RHIT : ST_RMISS;
      end
    end
    if (send_go) begin
      m_tdata <= {2'b00, res2, res1};
    end
  end

  a_accept_looks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_LOOK))
    else $error("accepted word did not start a lookup");

  a_status_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[5:3] == ST_NONE) ==
                  (m_tdata[2:0] == ST_RHIT || m_tdata[2:0] == ST_WHIT)))
    else $error("L2 status inconsistent with L1 status");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_SEND))
    else $error("result presented outside send step");

  a_no_fill_on_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACT && cmd) |-> (!l1_we && !l2_we))
    else $error("write access allocated a line");

endmodule
